[sv/rpnc_pkg.sv]
// Package with the operation codes, status codes and sizes of the RPN calculator.
package rpnc_pkg;

  localparam int unsigned DefStackDepth = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned KindW = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned DepthOutW = 5;

  typedef enum logic [3:0] {
    KIND_PUSH  = 4'd0,
    KIND_ADD   = 4'd1,
    KIND_SUB   = 4'd2,
    KIND_MUL   = 4'd3,
    KIND_DIV   = 4'd4,
    KIND_MOD   = 4'd5,
    KIND_POW   = 4'd6,
    KIND_DROP  = 4'd7,
    KIND_SWAP  = 4'd8,
    KIND_CLEAR = 4'd9,
    KIND_PEEK  = 4'd10
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNDERFLOW  = 3'd1,
    ST_FULL       = 3'd2,
    ST_DIVZERO    = 3'd3,
    ST_ZERONEGPOW = 3'd4
  } status_e;

  // Request to the shared arithmetic unit.
  typedef struct packed {
    logic       start;
    logic [3:0] kind;
  } alu_req_t;

endpackage

[sv/rpn_stack_calculator.sv]
// Top level of the RPN stack calculator: stack memory, sequencer and result port.
//
//   channel | handshake              | words
//   --------+------------------------+-------------------------------------------
//   command | start_i, busy_o        | kind_i, operand_value_i
//   result  | done_o (one-cycle)     | status_o, stack_depth_o, top_valid_o,
//           |                        | top_value_o
//
// Div and mod take one quotient bit per cycle in the shared unit; pow takes a multiply
// step and a square step per exponent bit. Zero divisors and zero to a negative power
// end before the unit is started, and other negative exponents bypass the unit.
// Reset empties the stack; stored entries are not cleared. busy_o is high from the
// accepted word until the cycle of its result strobe. The receiver cannot stall results.
module rpn_stack_calculator
  import rpnc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DefStackDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [KindW-1:0]      kind_i,
  input  logic signed [DataW-1:0] operand_value_i,
  output logic                  done_o,
  output logic [StatusW-1:0]    status_o,
  output logic [DepthOutW-1:0]  stack_depth_o,
  output logic                  top_valid_o,
  output logic signed [DataW-1:0] top_value_o
);

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CountW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_WAIT_B,
    S_EXEC,
    S_ALU,
    S_WR,
    S_SWAP2,
    S_RD_TOP,
    S_REPORT
  } state_e;

  state_e               state_q;
  logic [3:0]           kind_q;
  logic [DataW-1:0]     val_q;
  logic [CountW-1:0]    count_q;
  logic [StatusW-1:0]   status_q;
  logic [DataW-1:0]     a_q;
  logic [DataW-1:0]     b_q;
  logic                 done_q;
  logic [DataW-1:0]     top_q;

  // Stack memory, one write and one registered read a cycle.
  logic [DataW-1:0]     mem_q [STACK_DEPTH];
  logic                 we;
  logic [AddrW-1:0]     waddr;
  logic [DataW-1:0]     wdata;
  logic [AddrW-1:0]     raddr;
  logic [DataW-1:0]     rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  alu_req_t             alu_req;
  logic                 alu_done;
  logic [DataW-1:0]     alu_res;

  rpnc_alu u_alu (
    .clk_i,
    .rst_ni,
    .req_i    (alu_req),
    .a_i      (a_q),
    .b_i      (b_q),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  logic [AddrW-1:0] idx1;
  logic [AddrW-1:0] idx2;
  assign idx1 = AddrW'(count_q - 1'b1);
  assign idx2 = AddrW'(count_q - 2'd2);

  // Memory port control follows the state.
  always_comb begin
    we      = 1'b0;
    waddr   = idx1;
    wdata   = val_q;
    raddr   = idx1;
    alu_req = '{start: 1'b0, kind: kind_q};
    case (state_q)
      S_RD_A:   raddr = idx1;
      S_RD_B:   raddr = idx2;
      S_EXEC:   alu_req.start = 1'b1;
      S_SWAP2: begin
        we    = 1'b1;
        waddr = idx1;
        wdata = b_q;
      end
      S_WR: begin
        we    = 1'b1;
        waddr = idx1;
        wdata = val_q;
      end
      default: ;
    endcase
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign stack_depth_o = DepthOutW'(count_q);
  assign top_valid_o   = (count_q != '0);
  assign top_value_o   = (count_q != '0) ? top_q : '0;

  // Sequencer for one command word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            kind_q   <= kind_i;
            val_q    <= operand_value_i;
            status_q <= ST_OK;
            state_q  <= S_RD_TOP;
            case (kind_i) inside
              KIND_PUSH: begin
                if (count_q >= CountW'(STACK_DEPTH)) begin
                  status_q <= ST_FULL;
                end else begin
                  count_q <= count_q + 1'b1;
                  state_q <= S_WR;
                end
              end
              [KIND_ADD:KIND_POW], KIND_SWAP: begin
                if (count_q < CountW'(2)) begin
                  status_q <= ST_UNDERFLOW;
                end else begin
                  state_q <= S_RD_A;
                end
              end
              KIND_DROP: begin
                if (count_q == '0) begin
                  status_q <= ST_UNDERFLOW;
                end else begin
                  count_q <= count_q - 1'b1;
                end
              end
              KIND_PEEK: begin
                if (count_q == '0) begin
                  status_q <= ST_UNDERFLOW;
                end
              end
              KIND_CLEAR: count_q <= '0;
              default: ;
            endcase
          end
        end
        S_RD_A:   state_q <= S_RD_B;
        S_RD_B: begin
          a_q     <= rdata_q;
          state_q <= S_WAIT_B;
        end
        S_WAIT_B: begin
          if (kind_q == KIND_SWAP) begin
            // Write old top below, then old second on top.
            val_q   <= rdata_q;
            b_q     <= a_q;
            count_q <= count_q - 1'b1;
            state_q <= S_SWAP2;
          end else begin
            b_q <= rdata_q;
            if ((kind_q == KIND_DIV || kind_q == KIND_MOD) && a_q == '0) begin
              count_q  <= count_q - 2'd2;
              status_q <= ST_DIVZERO;
              state_q  <= S_RD_TOP;
            end else if (kind_q == KIND_POW && a_q[DataW-1]) begin
              if (rdata_q == '0) begin
                count_q  <= count_q - 2'd2;
                status_q <= ST_ZERONEGPOW;
                state_q  <= S_RD_TOP;
              end else begin
                val_q   <= (rdata_q == {{(DataW-1){1'b0}}, 1'b1}) ? 32'd1 :
                           (&rdata_q) ? (a_q[0] ? '1 : 32'd1) : '0;
                count_q <= count_q - 1'b1;
                state_q <= S_WR;
              end
            end else begin
              count_q <= count_q - 2'd2;
              state_q <= S_EXEC;
            end
          end
        end
        S_SWAP2: begin
          count_q <= count_q + 1'b1;
          state_q <= S_WR;
        end
        S_EXEC:   state_q <= S_ALU;
        S_ALU: begin
          if (alu_done) begin
            val_q   <= alu_res;
            count_q <= count_q + 1'b1;
            state_q <= S_WR;
          end
        end
        S_WR:     state_q <= S_RD_TOP;
        S_RD_TOP: state_q <= S_REPORT;
        S_REPORT: begin
          top_q   <= rdata_q;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/rpnc_alu.sv]
// Shared iterative arithmetic unit: add, subtract, multiply, divide, modulo and power.
module rpnc_alu
  import rpnc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alu_req_t          req_i,
  input  logic [DataW-1:0]  a_i,
  input  logic [DataW-1:0]  b_i,
  output logic              done_o,
  output logic [DataW-1:0]  result_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_POW,
    S_FIX
  } state_e;

  localparam int unsigned CntW = $clog2(DataW) + 1;

  state_e            state_q;
  logic [3:0]        kind_q;
  logic [DataW-1:0]  acc_q;     // quotient bits, or power accumulator
  logic [DataW-1:0]  rem_q;     // partial remainder
  logic [DataW-1:0]  opa_q;     // divisor magnitude, or exponent
  logic [DataW-1:0]  opb_q;     // dividend magnitude, or base
  logic              aneg_q;
  logic              bneg_q;
  logic              sqr_q;     // power: alternates multiply and square
  logic [CntW-1:0]   cnt_q;
  logic              done_q;
  logic [DataW-1:0]  res_q;

  // One shared multiplier, with operands chosen by the step.
  logic [DataW-1:0]  mul_x;
  logic [DataW-1:0]  mul_y;
  logic [DataW-1:0]  mul_p;
  logic [DataW:0]    trial;
  logic [DataW-1:0]  rem_sh;

  always_comb begin
    mul_x = a_i;
    mul_y = b_i;
    if (state_q == S_POW) begin
      mul_x = sqr_q ? opb_q : acc_q;
      mul_y = opb_q;
    end
  end
  assign mul_p  = mul_x * mul_y;
  assign rem_sh = {rem_q[DataW-2:0], opb_q[DataW-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, opa_q};

  assign done_o   = done_q;
  assign result_o = res_q;

  // Sequencer: one quotient bit per cycle, or one multiply per cycle for power.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            kind_q <= req_i.kind;
            aneg_q <= a_i[DataW-1];
            bneg_q <= b_i[DataW-1];
            case (req_i.kind)
              KIND_ADD: begin res_q <= b_i + a_i; done_q <= 1'b1; end
              KIND_SUB: begin res_q <= b_i - a_i; done_q <= 1'b1; end
              KIND_MUL: begin res_q <= mul_p;     done_q <= 1'b1; end
              KIND_DIV, KIND_MOD: begin
                opa_q   <= a_i[DataW-1] ? (~a_i + 1'b1) : a_i;
                opb_q   <= b_i[DataW-1] ? (~b_i + 1'b1) : b_i;
                rem_q   <= '0;
                acc_q   <= '0;
                cnt_q   <= CntW'(DataW);
                state_q <= S_DIV;
              end
              KIND_POW: begin
                opa_q   <= a_i;
                opb_q   <= b_i;
                acc_q   <= {{(DataW-1){1'b0}}, 1'b1};
                sqr_q   <= 1'b0;
                state_q <= S_POW;
              end
              default: begin res_q <= '0; done_q <= 1'b1; end
            endcase
          end
        end
        S_DIV: begin
          if (!trial[DataW]) begin
            rem_q <= trial[DataW-1:0];
          end else begin
            rem_q <= rem_sh;
          end
          acc_q <= {acc_q[DataW-2:0], ~trial[DataW]};
          opb_q <= {opb_q[DataW-2:0], 1'b0};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            state_q <= S_FIX;
          end
        end
        S_POW: begin
          // Multiply step, then square step, per exponent bit.
          if (!sqr_q) begin
            if (opa_q == '0) begin
              res_q   <= acc_q;
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              if (opa_q[0]) begin
                acc_q <= mul_p;
              end
              sqr_q <= 1'b1;
            end
          end else begin
            opb_q <= mul_p;
            opa_q <= opa_q >> 1;
            sqr_q <= 1'b0;
          end
        end
        S_FIX: begin
          if (kind_q == KIND_DIV) begin
            res_q <= (aneg_q != bneg_q) ? (~acc_q + 1'b1) : acc_q;
          end else begin
            res_q <= bneg_q ? (~rem_q + 1'b1) : rem_q;
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/rpnc_checker.sv]
// Port-level checker for the RPN stack calculator, bound to the top level.
module rpnc_checker
  import rpnc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic                  done_o,
  input logic [StatusW-1:0]    status_o,
  input logic [DepthOutW-1:0]  stack_depth_o,
  input logic                  top_valid_o,
  input logic [DataW-1:0]      top_value_o
);

  // An accepted word makes the block busy.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("not busy after accepted word");

  // A result strobe ends the busy period.
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("busy during result strobe");

  // An empty stack reports a zero top value.
  a_empty_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !top_valid_o) |-> (top_value_o == '0)) else $error("empty top not zero");

  // Errors other than zero divisor or power leave the depth unchanged.
  a_err_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_UNDERFLOW || status_o == ST_FULL))
      |-> $stable(stack_depth_o)) else $error("depth changed on error");

endmodule

bind rpn_stack_calculator rpnc_checker u_rpnc_checker (.*);

[dv/tb_rpn_stack_calculator.sv]
// Testbench for the RPN stack calculator: directed and random command words checked against a predictor.
module tb_rpn_stack_calculator;
  import rpnc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = DefStackDepth;
  localparam longint unsigned CycleLimit = 2_000_000;

  // Result word as predicted from the command stream.
  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [DepthOutW-1:0] depth;
    logic                 top_valid;
    logic [DataW-1:0]     top_value;
  } calc_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic [KindW-1:0]        kind_i;
  logic signed [DataW-1:0] operand_value_i;
  logic                    done_o;
  logic [StatusW-1:0]      status_o;
  logic [DepthOutW-1:0]    stack_depth_o;
  logic                    top_valid_o;
  logic signed [DataW-1:0] top_value_o;

  // Predictor state.
  logic [DataW-1:0] model_stack [Depth];
  int unsigned      model_count;
  calc_result_t     expected_results [$];
  int unsigned      error_count;
  longint unsigned  cycle_count;
  int unsigned      burst_left;

  rpn_stack_calculator #(.STACK_DEPTH(Depth)) u_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .kind_i,
    .operand_value_i,
    .done_o,
    .status_o,
    .stack_depth_o,
    .top_valid_o,
    .top_value_o
  );

  // Clock generation.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Wrapping power by square-and-multiply.
  function automatic logic [DataW-1:0] wrap_power(logic [DataW-1:0] base,
                                                  logic [DataW-1:0] expo);
    logic [DataW-1:0] acc;
    acc = 1;
    while (expo != 0) begin
      if (expo[0]) acc = acc * base;
      base = base * base;
      expo = expo >> 1;
    end
    return acc;
  endfunction

  // Apply one command word to the predicted stack and queue its result.
  function automatic void predict_command(logic [KindW-1:0] kind, logic [DataW-1:0] value);
    logic [DataW-1:0] a, b, r, ma, mb, t;
    logic [StatusW-1:0] st;
    logic keep;
    calc_result_t res;
    st = ST_OK;
    keep = 1'b1;
    r = '0;
    if (kind == KIND_PUSH) begin
      if (model_count >= Depth) st = ST_FULL;
      else begin
        model_stack[model_count] = value;
        model_count++;
      end
    end else if (kind >= KIND_ADD && kind <= KIND_POW) begin
      if (model_count < 2) st = ST_UNDERFLOW;
      else begin
        a = model_stack[model_count-1];
        b = model_stack[model_count-2];
        model_count -= 2;
        case (kind)
          KIND_ADD: r = b + a;
          KIND_SUB: r = b - a;
          KIND_MUL: r = b * a;
          KIND_DIV, KIND_MOD: begin
            if (a == 0) begin
              st = ST_DIVZERO;
              keep = 1'b0;
            end else begin
              ma = a[DataW-1] ? -a : a;
              mb = b[DataW-1] ? -b : b;
              if (kind == KIND_DIV) begin
                r = mb / ma;
                if (a[DataW-1] != b[DataW-1]) r = -r;
              end else begin
                r = mb % ma;
                if (b[DataW-1]) r = -r;
              end
            end
          end
          default: begin
            if (a[DataW-1]) begin
              if (b == 0) begin
                st = ST_ZERONEGPOW;
                keep = 1'b0;
              end else if (b == 1) r = 1;
              else if (b == '1) r = a[0] ? '1 : 1;
              else r = 0;
            end else begin
              r = wrap_power(b, a);
            end
          end
        endcase
        if (keep) begin
          model_stack[model_count] = r;
          model_count++;
        end
      end
    end else if (kind == KIND_DROP) begin
      if (model_count < 1) st = ST_UNDERFLOW;
      else model_count--;
    end else if (kind == KIND_SWAP) begin
      if (model_count < 2) st = ST_UNDERFLOW;
      else begin
        t = model_stack[model_count-1];
        model_stack[model_count-1] = model_stack[model_count-2];
        model_stack[model_count-2] = t;
      end
    end else if (kind == KIND_CLEAR) begin
      model_count = 0;
    end else if (kind == KIND_PEEK) begin
      if (model_count < 1) st = ST_UNDERFLOW;
    end
    res.status = st;
    res.depth = model_count[DepthOutW-1:0];
    res.top_valid = model_count > 0;
    res.top_value = (model_count > 0) ? model_stack[model_count-1] : '0;
    expected_results.push_back(res);
  endfunction

  // Send one command word, with random gaps between bursts.
  task automatic send_command(logic [KindW-1:0] kind, logic [DataW-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        start_i <= 1'b0;
        kind_i <= 4'($urandom);
        operand_value_i <= $urandom;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start_i <= 1'b1;
    kind_i <= kind;
    operand_value_i <= value;
    // The word is taken at the first edge where busy_o was low before it.
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_command(kind, value);
  endtask

  // Compare each result word with the oldest expectation.
  always @(posedge clk_i) begin
    calc_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          error_count++;
        end
        if (stack_depth_o !== want.depth) begin
          $error("stack_depth: expected %0d, actual %0d", want.depth, stack_depth_o);
          error_count++;
        end
        if (top_valid_o !== want.top_valid) begin
          $error("top_valid: expected %0d, actual %0d", want.top_valid, top_valid_o);
          error_count++;
        end
        if (top_value_o !== want.top_value) begin
          $error("top_value: expected %h, actual %h", want.top_value, top_value_o);
          error_count++;
        end
      end
    end
  end

  // Pick an operand biased toward the interesting corners.
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 6)) - 3);
      3: return 32'($urandom_range(0, 40));
      default: return $urandom;
    endcase
  endfunction

  // Underflow, full stack and the unused kinds.
  task automatic test_stack_limits();
    send_command(KIND_ADD, 0);
    send_command(KIND_DROP, 0);
    send_command(KIND_PEEK, 0);
    send_command(KIND_SWAP, 0);
    send_command(4'd11, 0);
    send_command(4'd15, '1);
    for (int i = 0; i <= Depth; i++) send_command(KIND_PUSH, i[0] ? 32'h8000_0000 : 32'h7fff_ffff);
    send_command(KIND_SWAP, 0);
    send_command(KIND_PEEK, 0);
    send_command(KIND_CLEAR, 0);
  endtask

  // Arithmetic corners: wrap, zero divisor, negative and zero powers.
  task automatic test_arith_corners();
    send_command(KIND_PUSH, 32'h8000_0000);
    send_command(KIND_PUSH, '1);
    send_command(KIND_DIV, 0);
    send_command(KIND_PUSH, 32'h8000_0000);
    send_command(KIND_PUSH, '1);
    send_command(KIND_MOD, 0);
    send_command(KIND_PUSH, 7);
    send_command(KIND_PUSH, 0);
    send_command(KIND_DIV, 0);
    send_command(KIND_PUSH, 0);
    send_command(KIND_PUSH, 32'hffff_fffd);
    send_command(KIND_POW, 0);
    send_command(KIND_PUSH, '1);
    send_command(KIND_PUSH, 32'h8000_0001);
    send_command(KIND_POW, 0);
    send_command(KIND_PUSH, 0);
    send_command(KIND_PUSH, 0);
    send_command(KIND_POW, 0);
    send_command(KIND_CLEAR, 0);
  endtask

  // Random programs: mostly pushes followed by operations, plus noise.
  task automatic test_random_programs();
    logic [KindW-1:0] kind;
    for (int n = 0; n < 1950; n++) begin
      if ($urandom_range(0, 19) == 0) kind = 4'($urandom);
      else if (model_count < 2 || $urandom_range(0, 2) == 0) kind = KIND_PUSH;
      else if ($urandom_range(0, 39) == 0) kind = KIND_CLEAR;
      else kind = 4'($urandom_range(KIND_ADD, KIND_PEEK - 1));
      if (kind == KIND_CLEAR && $urandom_range(0, 1)) kind = KIND_SWAP;
      send_command(kind, pick_value());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    kind_i = '0;
    operand_value_i = '0;
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    model_count = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_stack_limits();
    test_arith_corners();
    test_random_programs();
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
